// ===== hw/rtl/ksa_pkg.sv =====
// ----------------------------------------------------------------------------
// ksa_pkg: shared types and constants of the keypad scanner
// Key table, payload structs, the item passed from front to back and key decode helpers.
// ----------------------------------------------------------------------------
package ksa_pkg;

  localparam int unsigned NumKeys = 13;

  localparam logic [31:0] SD_RO_BIT   = 32'h0002_0000;
  localparam logic [31:0] USB_PWR_BIT = 32'h0004_0000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIRST_DELAY  = 2'd0;
  localparam logic [1:0] CFG_REPEAT_DELAY = 2'd1;
  localparam logic [1:0] CFG_REMOTE_EN    = 2'd2;

  // Key table in priority order. A key is down when all of its mask bits
  // are low in the selected word (1: word one, 0: word two).
  localparam logic [NumKeys-1:0] KEY_IN_G1 = 13'b0_0000_1110_0000;
  localparam logic [31:0] KEY_MASK [NumKeys] = '{
    32'h0000_0010, 32'h0000_0020, 32'h0000_0080, 32'h0000_0040,
    32'h0000_0100, 32'hC000_0000, 32'h8000_0000, 32'h4000_0000,
    32'h0000_0004, 32'h0000_0008, 32'h0000_0200, 32'h0000_0400,
    32'h0000_0800
  };

  typedef struct packed {
    logic [31:0] raw_group1;
    logic [31:0] raw_group2;
    logic [31:0] now_ms;
  } ksa_in_t;

  typedef struct packed {
    logic [3:0]  pressed_key;
    logic [3:0]  clicked_key;
    logic [3:0]  repeat_key;
    logic        usb_present;
    logic [15:0] usb_pulse_width;
    logic [31:0] status_group2;
  } ksa_out_t;

  // Classified scan handed from the front to the back.
  typedef struct packed {
    logic [NumKeys-1:0] down;
    logic [3:0]         pressed_key;
    logic [3:0]         clicked_key;
    logic               usb_present;
    logic [31:0]        status_group2;
    logic [31:0]        now_ms;
  } ksa_cls_t;

  // Per-key down flags for one pair of key words.
  function automatic logic [NumKeys-1:0] key_active_vec(logic [31:0] g1, logic [31:0] g2);
    logic [NumKeys-1:0] v;
    v = '0;
    for (int i = 0; i < NumKeys; i++) begin
      v[i] = KEY_IN_G1[i] ? ((g1 & KEY_MASK[i]) == 32'h0)
                          : ((g2 & KEY_MASK[i]) == 32'h0);
    end
    return v;
  endfunction

  // Code of the first set flag, counting from 1; 0 when none is set.
  function automatic logic [3:0] first_code(logic [NumKeys-1:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (v[i]) begin
        c = 4'(i + 1);
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ksa_front.sv =====
// ----------------------------------------------------------------------------
// ksa_front: scan classification
// Decodes the key words, finds pressed and clicked keys, builds the status.
// ----------------------------------------------------------------------------
module ksa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  ksa_pkg::ksa_in_t in_i,
  input  logic             remote_en_i,
  output ksa_pkg::ksa_cls_t cls_o
);
  import ksa_pkg::*;

  logic [11:0]        prev_keys_q, prev_keys_d;
  logic [NumKeys-1:0] down_now, down_prev;
  logic [31:0]        status;

  always_comb begin
    down_now  = key_active_vec(in_i.raw_group1, in_i.raw_group2);
    // Previous scan rebuilt as key words; only the key bits matter.
    down_prev = key_active_vec({prev_keys_q[1:0], 30'h0},
                               {20'h0, prev_keys_q[11:2], 2'b00});
    prev_keys_d = {in_i.raw_group2[11:2], in_i.raw_group1[31:30]};

    status = in_i.raw_group2 & ~SD_RO_BIT;
    if (remote_en_i) begin
      status = status & ~USB_PWR_BIT;
    end

    cls_o.down          = down_now;
    cls_o.pressed_key   = first_code(down_now);
    cls_o.clicked_key   = first_code(down_now & ~down_prev);
    cls_o.usb_present   = (in_i.raw_group2 & USB_PWR_BIT) != 32'h0;
    cls_o.status_group2 = status;
    cls_o.now_ms        = in_i.now_ms;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_keys_q <= 12'hFFF;
    end else if (take_i) begin
      prev_keys_q <= prev_keys_d;
    end
  end

endmodule

// ===== hw/rtl/ksa_fifo.sv =====
// ----------------------------------------------------------------------------
// ksa_fifo: two-entry queue between front and back
// Lets the input side keep taking items while the back waits.
// ----------------------------------------------------------------------------
module ksa_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ksa_pkg::ksa_cls_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ksa_pkg::ksa_cls_t data_o
);
  import ksa_pkg::*;

  ksa_cls_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ksa_back.sv =====
// ----------------------------------------------------------------------------
// ksa_back: autorepeat and USB pulse timing
// Keeps the held key and pulse counter and fills the output register.
// ----------------------------------------------------------------------------
module ksa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ksa_pkg::ksa_cls_t cls_i,
  output logic              pop_o,
  input  logic [15:0]       first_delay_i,
  input  logic [15:0]       repeat_delay_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ksa_pkg::ksa_out_t out_data_o
);
  import ksa_pkg::*;

  logic [3:0]  held_q, held_d;
  logic [31:0] last_q, last_d;
  logic        rpt_q, rpt_d;
  logic [15:0] usb_cnt_q, usb_cnt_d;
  logic        out_valid_q;
  ksa_out_t    out_q, out_d;

  logic [3:0]  hidx;
  logic        held_down;
  logic [31:0] elapsed;
  logic [15:0] delay;

  assign pop_o       = valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    hidx      = held_q - 4'd1;
    held_down = (held_q != 4'd0) && cls_i.down[hidx];
    elapsed   = cls_i.now_ms - last_q;
    delay     = rpt_q ? repeat_delay_i : first_delay_i;

    held_d    = held_q;
    last_d    = last_q;
    rpt_d     = rpt_q;
    usb_cnt_d = usb_cnt_q;

    out_d.pressed_key     = cls_i.pressed_key;
    out_d.clicked_key     = cls_i.clicked_key;
    out_d.repeat_key      = 4'd0;
    out_d.usb_present     = cls_i.usb_present;
    out_d.usb_pulse_width = 16'd0;
    out_d.status_group2   = cls_i.status_group2;

    if (cls_i.clicked_key != 4'd0) begin
      // A new click restarts the repeat timing on that key.
      held_d           = cls_i.clicked_key;
      rpt_d            = 1'b0;
      last_d           = cls_i.now_ms;
      out_d.repeat_key = cls_i.clicked_key;
    end else if (held_down) begin
      if (elapsed > {16'h0, delay}) begin
        rpt_d            = 1'b1;
        last_d           = cls_i.now_ms;
        out_d.repeat_key = held_q;
      end
    end else begin
      held_d = 4'd0;
    end

    if (cls_i.usb_present) begin
      if (usb_cnt_q != 16'hFFFF) begin
        usb_cnt_d = usb_cnt_q + 16'd1;
      end
    end else if (usb_cnt_q != 16'd0) begin
      out_d.usb_pulse_width = usb_cnt_q;
      usb_cnt_d             = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 4'd0;
      last_q      <= 32'd0;
      rpt_q       <= 1'b0;
      usb_cnt_q   <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        held_q      <= held_d;
        last_q      <= last_d;
        rpt_q       <= rpt_d;
        usb_cnt_q   <= usb_cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 4'd13)
    else $error("held key code out of range");

  a_click_repeats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.clicked_key != 4'd0 |-> out_q.repeat_key == out_q.clicked_key)
    else $error("click not reported on the repeat output");

  a_click_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.clicked_key != 4'd0 |->
      out_q.pressed_key != 4'd0 && out_q.pressed_key <= out_q.clicked_key)
    else $error("clicked key ahead of the first pressed key");

  a_pulse_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.usb_pulse_width != 16'd0 |-> !out_q.usb_present)
    else $error("pulse width reported while USB power still present");

endmodule

// ===== hw/rtl/keypad_scan_autorepeat.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_autorepeat: keypad scanner with key autorepeat
// Priority-encodes 13 keys, reports clicks and autorepeats, times USB pulses.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i / in_stall_o  raw_group1, raw_group2, now_ms
//  out       output     out_valid_o / out_stall_i pressed/clicked/repeat keys,
//                                                usb_present, usb_pulse_width,
//                                                status_group2
//  cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One item is accepted per cycle while the queue is not full, and its result
// goes through the queue into the output register. The front holds the
// previous-scan key bits and classifies each scan in the cycle it is taken;
// the back holds the autorepeat timer and the USB pulse counter and retires
// one item a cycle while no result waits on a stalled output. A two-entry
// queue sits between them, so input is taken while a result waits on a
// stalled output; input stalls only once that queue is full. Reset clears
// all control state and loads the register defaults (first delay 500 ms,
// repeat delay 175 ms, remote enable off); there is no clearing pass.
module keypad_scan_autorepeat (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ksa_pkg::ksa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ksa_pkg::ksa_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);
  import ksa_pkg::*;

  logic [15:0] first_delay_q;
  logic [15:0] repeat_delay_q;
  logic        remote_en_q;

  logic     take;
  logic     q_full, q_valid, q_pop;
  ksa_cls_t cls_in, cls_out;

  // Configuration registers. Writes to an unused index fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q  <= 16'd500;
      repeat_delay_q <= 16'd175;
      remote_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_DELAY:  first_delay_q  <= cfg_data_i;
        CFG_REPEAT_DELAY: repeat_delay_q <= cfg_data_i;
        CFG_REMOTE_EN:    remote_en_q    <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  ksa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .in_i        (in_data_i),
    .remote_en_i (remote_en_q),
    .cls_o       (cls_in)
  );

  ksa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (cls_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cls_out)
  );

  ksa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .cls_i          (cls_out),
    .pop_o          (q_pop),
    .first_delay_i  (first_delay_q),
    .repeat_delay_i (repeat_delay_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule
